@@ rtl/core/tlpm_pkg.sv @@
package tlpm_pkg;

   localparam int LEVEL_ONE_DEPTH = 2048;
   localparam int LEVEL_TWO_DEPTH = 1024;
   localparam int L1_ADDR_W = $clog2(LEVEL_ONE_DEPTH);
   localparam int L2_ADDR_W = $clog2(LEVEL_TWO_DEPTH);
   localparam int L1_VALUE_W = 5;
   localparam int ENTRY_W = 24;
   localparam int VADDR_W = 24;
   localparam int OFFSET_W = 8;
   localparam int PAGE_SEL_W = L2_ADDR_W - L1_VALUE_W;

   localparam logic [VADDR_W-1:0] WINDOW_MASK   = 24'o77700000;
   localparam logic [VADDR_W-1:0] FRAME_WINDOW  = 24'o77000000;
   localparam logic [VADDR_W-1:0] COLOR_WINDOW  = 24'o77200000;
   localparam logic [VADDR_W-1:0] TOP_PAGE_MASK = 24'o77777400;
   localparam logic [VADDR_W-1:0] TOP_PAGE      = 24'o77377400;
   localparam logic [ENTRY_W-1:0] FRAME_ENTRY   = 24'o60036000;
   localparam logic [ENTRY_W-1:0] TOP_ENTRY     = 24'o60036777;

   typedef enum logic [1:0] {
      OP_TRANSLATE = 2'd0,
      OP_WRITE_L1  = 2'd1,
      OP_WRITE_L2  = 2'd2,
      OP_UNUSED    = 2'd3
   } operation_type;

   typedef enum logic [1:0] {
      SRC_MAP   = 2'd0,
      SRC_FRAME = 2'd1,
      SRC_TOP   = 2'd2
   } source_type;

   typedef struct packed {
      logic                  en;
      logic [L1_ADDR_W-1:0]  index;
      logic [L1_VALUE_W-1:0] data;
   } l1_write_type;

   typedef struct packed {
      logic                 en;
      logic [L2_ADDR_W-1:0] index;
      logic [ENTRY_W-1:0]   data;
   } l2_write_type;

endpackage

@@ rtl/core/tlpm_level_one_map.sv @@
module tlpm_level_one_map (
   input  logic                                     clock,
   input  tlpm_pkg::l1_write_type                   wr,
   input  logic                                     rd_en,
   input  logic [tlpm_pkg::L1_ADDR_W-1:0]           rd_addr,
   output logic [tlpm_pkg::L1_VALUE_W-1:0]          rd_data
);

   logic [tlpm_pkg::L1_VALUE_W-1:0] mem [tlpm_pkg::LEVEL_ONE_DEPTH];
   logic [tlpm_pkg::L1_VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tlpm_level_two_map.sv @@
module tlpm_level_two_map (
   input  logic                                  clock,
   input  tlpm_pkg::l2_write_type                wr,
   input  logic                                  rd_en,
   input  logic [tlpm_pkg::L2_ADDR_W-1:0]        rd_addr,
   output logic [tlpm_pkg::ENTRY_W-1:0]          rd_data
);

   logic [tlpm_pkg::ENTRY_W-1:0] mem [tlpm_pkg::LEVEL_TWO_DEPTH];
   logic [tlpm_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/two_level_page_map_translate_core.sv @@
// Two-level page map address translation.
// The request channel carries one transaction per item: a translate, a write
// to a first-level map entry, or a write to a second-level map entry. Writes
// are committed at the accepting clock edge and produce no response.
// A translate reads the first-level map at the accepting edge and the
// second-level map at the edge where it leaves the pipeline slot; its
// response is registered at that edge and held on the response channel.
// Fixed windows skip the map but follow the same path.
// One transaction is accepted every cycle while the response side keeps up;
// each map has its own read and write port, so a write never waits on a read.
// When the receiver stalls, the response is held and one translate waits
// between the two memory reads; req_stall rises only when that slot is full
// and cannot advance. Writes never overtake or lag a translate, because each
// map is read and written in program order at its own port.
// Reset clears the pipeline valid flags only; map contents are undefined
// until written, and no transaction may read an entry never written.
module two_level_page_map_translate_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic [tlpm_pkg::VADDR_W-1:0]          req_virtual_address,
   input  logic [tlpm_pkg::L1_ADDR_W-1:0]        req_map_index,
   input  logic [tlpm_pkg::ENTRY_W-1:0]          req_map_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tlpm_pkg::ENTRY_W-1:0]          rsp_physical_entry,
   output logic [tlpm_pkg::L1_VALUE_W-1:0]       rsp_level_one_value,
   output logic                                  rsp_level_one_valid,
   output logic [tlpm_pkg::OFFSET_W-1:0]         rsp_page_offset
);

   tlpm_pkg::operation_type op;
   logic                    accept;
   logic                    accept_translate;
   logic                    advance;
   tlpm_pkg::source_type    src_in;

   logic                    s1_valid_ff, s1_valid_in;
   tlpm_pkg::source_type    s1_src_ff;
   logic [tlpm_pkg::PAGE_SEL_W-1:0] s1_page_ff;
   logic [tlpm_pkg::OFFSET_W-1:0]   s1_offset_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   tlpm_pkg::source_type    rsp_src_ff;
   logic [tlpm_pkg::L1_VALUE_W-1:0] rsp_l1_ff;
   logic [tlpm_pkg::OFFSET_W-1:0]   rsp_offset_ff;

   tlpm_pkg::l1_write_type  l1_wr;
   tlpm_pkg::l2_write_type  l2_wr;
   logic [tlpm_pkg::L1_VALUE_W-1:0] l1_rd_data;
   logic [tlpm_pkg::ENTRY_W-1:0]    l2_rd_data;

   assign op = tlpm_pkg::operation_type'(req_operation);
   assign advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign accept_translate = accept && (op == tlpm_pkg::OP_TRANSLATE);

   always_comb begin
      if (((req_virtual_address & tlpm_pkg::WINDOW_MASK) == tlpm_pkg::FRAME_WINDOW) ||
          ((req_virtual_address & tlpm_pkg::WINDOW_MASK) == tlpm_pkg::COLOR_WINDOW)) begin
         src_in = tlpm_pkg::SRC_FRAME;
      end else if ((req_virtual_address & tlpm_pkg::TOP_PAGE_MASK) == tlpm_pkg::TOP_PAGE) begin
         src_in = tlpm_pkg::SRC_TOP;
      end else begin
         src_in = tlpm_pkg::SRC_MAP;
      end
   end

   always_comb begin
      l1_wr.en    = accept && (op == tlpm_pkg::OP_WRITE_L1);
      l1_wr.index = req_map_index;
      l1_wr.data  = req_map_data[tlpm_pkg::L1_VALUE_W-1:0];
      l2_wr.en    = accept && (op == tlpm_pkg::OP_WRITE_L2);
      l2_wr.index = req_map_index[tlpm_pkg::L2_ADDR_W-1:0];
      l2_wr.data  = req_map_data;
   end

   tlpm_level_one_map u_level_one (
      .clock   (clock),
      .wr      (l1_wr),
      .rd_en   (accept_translate),
      .rd_addr (req_virtual_address[tlpm_pkg::VADDR_W-1 -: tlpm_pkg::L1_ADDR_W]),
      .rd_data (l1_rd_data)
   );

   tlpm_level_two_map u_level_two (
      .clock   (clock),
      .wr      (l2_wr),
      .rd_en   (advance),
      .rd_addr ({l1_rd_data, s1_page_ff}),
      .rd_data (l2_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (accept_translate) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_translate) begin
         s1_src_ff    <= src_in;
         s1_page_ff   <= req_virtual_address[tlpm_pkg::OFFSET_W +: tlpm_pkg::PAGE_SEL_W];
         s1_offset_ff <= req_virtual_address[tlpm_pkg::OFFSET_W-1:0];
      end
      if (advance) begin
         rsp_src_ff    <= s1_src_ff;
         rsp_l1_ff     <= l1_rd_data;
         rsp_offset_ff <= s1_offset_ff;
      end
   end

   always_comb begin
      case (rsp_src_ff)
         tlpm_pkg::SRC_FRAME: begin
            rsp_physical_entry  = tlpm_pkg::FRAME_ENTRY;
            rsp_level_one_value = '0;
            rsp_level_one_valid = 1'b0;
         end
         tlpm_pkg::SRC_TOP: begin
            rsp_physical_entry  = tlpm_pkg::TOP_ENTRY;
            rsp_level_one_value = '0;
            rsp_level_one_valid = 1'b0;
         end
         default: begin
            rsp_physical_entry  = l2_rd_data;
            rsp_level_one_value = rsp_l1_ff;
            rsp_level_one_valid = 1'b1;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_page_offset = rsp_offset_ff;

   a_translate_enters_slot: assert property (@(posedge clock) disable iff (reset)
      accept_translate |=> s1_valid_ff)
      else $error("accepted translate did not enter the pipeline slot");

   a_advance_gives_response: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advancing translate did not produce a response");

   a_stall_needs_held_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked translate");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_src_ff)))
      else $error("stalled response was dropped or changed source");

endmodule
